// ===== rtl/hce_pkg.sv =====
package hce_pkg;

  // Block geometry.
  localparam int MAX_BLOCK = 4;
  localparam int BLK_IDX_W = $clog2(MAX_BLOCK);
  localparam int FILL_W    = 3;
  localparam int VAL_W     = 5;
  localparam int LETTER_W  = 7;
  localparam int KEY_ROW_W = MAX_BLOCK * VAL_W;
  localparam int CFG_IDX_W = 3;

  // Column sums reach at most 4 * 25 * 31, so 12 bits hold them.
  localparam int SUM_W = 12;
  localparam int QUO_W = 8;

  // Reduction modulo 26 by a scaled reciprocal: q = (s * 2521) >> 16.
  // The error stays below 1/26 for every sum up to 4095, so q is exact.
  localparam int MODULUS   = 26;
  localparam int MOD_SHIFT = 16;
  localparam int MOD_RECIP = ((1 << MOD_SHIFT) + MODULUS - 1) / MODULUS;
  localparam int PROD_W    = SUM_W + MOD_SHIFT;

  localparam logic [LETTER_W-1:0] LETTER_BASE = 7'd97;

  // Queue between the block collector and the column engine.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QPTR_W + 1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_ROW_0  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_ROW_1  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_ROW_2  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_ROW_3  = 3'd4;

  localparam logic [FILL_W-1:0] BLOCK_SIZE_RESET = 3'd2;

  typedef struct packed {
    logic [LETTER_W-1:0] plain_letter;
    logic                text_end;
  } in_req_t;

  typedef struct packed {
    logic [LETTER_W-1:0] cipher_letter;
    logic                last_of_run;
    logic                message_done;
  } out_req_t;

  // Key matrix indexed [row][column].
  typedef logic [MAX_BLOCK-1:0][MAX_BLOCK-1:0][VAL_W-1:0] key_mat_t;

  // One closed block: padded letter values, letters to emit, end flag.
  typedef struct packed {
    logic [MAX_BLOCK-1:0][VAL_W-1:0] vals;
    logic [FILL_W-1:0]               count;
    logic                            text_end;
  } job_t;

  // One column result on its way through the reduction pipeline.
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic             last_of_run;
    logic             message_done;
  } lane_t;

  // Map an ASCII code to 0..25; anything that is not a lowercase letter maps to 0.
  function automatic logic [VAL_W-1:0] letter_value(input logic [LETTER_W-1:0] code);
    logic [LETTER_W-1:0] diff;
    diff = code - LETTER_BASE;
    if (code >= LETTER_BASE && diff < LETTER_W'(MODULUS)) begin
      return diff[VAL_W-1:0];
    end
    return '0;
  endfunction

endpackage

// ===== rtl/hce_front.sv =====
module hce_front
  import hce_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  in_req_t           in_req_i,
  input  logic [FILL_W-1:0] block_size_i,
  input  logic              q_full_i,
  output logic              push_o,
  output job_t              job_o
);

  logic [FILL_W-1:0] fill_q, fill_d;
  logic [FILL_W-1:0] fill_next;
  logic [FILL_W-1:0] order;
  logic [FILL_W-1:0] count;
  logic [VAL_W-1:0]  val;
  logic              accept;
  logic              close;
  logic [MAX_BLOCK-1:0][VAL_W-1:0] store_q;

  // A new letter is taken whenever the job queue has room.
  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign val        = letter_value(in_req_i.plain_letter);

  // Clamp the configured block size to 1..MAX_BLOCK.
  always_comb begin
    if (block_size_i == '0) begin
      order = FILL_W'(1);
    end else if (block_size_i > FILL_W'(MAX_BLOCK)) begin
      order = FILL_W'(MAX_BLOCK);
    end else begin
      order = block_size_i;
    end
  end

  // The block closes when it reaches the order or the message ends.
  assign fill_next = fill_q + FILL_W'(1);
  assign close     = (fill_next >= order) || in_req_i.text_end;
  assign count     = (fill_next < order) ? fill_next : order;
  assign push_o    = accept && close;

  // Build the job from the stored letters plus the one arriving now.
  // Positions past the letter count are padded with zero.
  always_comb begin
    for (int k = 0; k < MAX_BLOCK; k++) begin
      if (FILL_W'(k) >= count) begin
        job_o.vals[k] = '0;
      end else if (FILL_W'(k) == fill_q) begin
        job_o.vals[k] = val;
      end else begin
        job_o.vals[k] = store_q[k];
      end
    end
    job_o.count    = count;
    job_o.text_end = in_req_i.text_end;
  end

  always_comb begin
    fill_d = fill_q;
    if (accept) begin
      fill_d = close ? '0 : fill_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  // The fill count stays below MAX_BLOCK between items, so the slot always exists.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      store_q[fill_q[BLK_IDX_W-1:0]] <= val;
    end
  end

endmodule

// ===== rtl/hce_queue.sv =====
module hce_queue
  import hce_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output job_t job_o
);

  job_t              slots_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_push;
  logic              do_pop;

  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign job_o   = slots_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

// ===== rtl/hce_back.sv =====
module hce_back
  import hce_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     job_valid_i,
  input  job_t     job_i,
  output logic     pop_o,
  input  key_mat_t key_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output out_req_t out_req_o
);

  logic [BLK_IDX_W-1:0] col_q, col_d;
  logic                 issue;
  logic                 last_col;
  lane_t                issue_lane;

  lane_t                a_q, b_q;
  logic                 a_valid_q, b_valid_q, out_valid_q;
  logic [QUO_W-1:0]     b_quo_q;
  logic [PROD_W-1:0]    recip_prod;
  logic [SUM_W-1:0]     rem_full;
  out_req_t             out_q;
  logic                 a_ready, b_ready, c_ready;

  // Each stage moves when the one after it is empty or moving.
  assign c_ready = !out_valid_q || !out_stall_i;
  assign b_ready = !b_valid_q || c_ready;
  assign a_ready = !a_valid_q || b_ready;

  // Column sequencer: one head job column per unstalled cycle.
  assign issue    = job_valid_i && a_ready;
  assign last_col = ({1'b0, col_q} + FILL_W'(1)) == job_i.count;
  assign pop_o    = issue && last_col;

  always_comb begin
    col_d = col_q;
    if (issue) begin
      col_d = last_col ? '0 : col_q + BLK_IDX_W'(1);
    end
  end

  // Dot product of the block with one key column.
  always_comb begin
    logic [SUM_W-1:0] acc;
    acc = '0;
    for (int k = 0; k < MAX_BLOCK; k++) begin
      acc = acc + SUM_W'(job_i.vals[k]) * SUM_W'(key_i[k][col_q]);
    end
    issue_lane.sum          = acc;
    issue_lane.last_of_run  = last_col;
    issue_lane.message_done = last_col && job_i.text_end;
  end

  // Quotient estimate by the scaled reciprocal.
  assign recip_prod = PROD_W'(a_q.sum) * PROD_W'(MOD_RECIP);

  // Remainder and letter code.
  assign rem_full = b_q.sum - SUM_W'(SUM_W'(b_quo_q) * SUM_W'(MODULUS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      a_valid_q   <= 1'b0;
      b_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      col_q <= col_d;
      if (a_ready) begin
        a_valid_q <= issue;
      end
      if (b_ready) begin
        b_valid_q <= a_valid_q;
      end
      if (c_ready) begin
        out_valid_q <= b_valid_q;
      end
    end
  end

  // Payload registers of the three stages.
  always_ff @(posedge clk_i) begin
    if (a_ready && issue) begin
      a_q <= issue_lane;
    end
    if (b_ready && a_valid_q) begin
      b_q     <= a_q;
      b_quo_q <= recip_prod[MOD_SHIFT +: QUO_W];
    end
    if (c_ready && b_valid_q) begin
      out_q.cipher_letter <= LETTER_BASE + LETTER_W'(rem_full[VAL_W-1:0]);
      out_q.last_of_run   <= b_q.last_of_run;
      out_q.message_done  <= b_q.message_done;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

endmodule

// ===== rtl/hill_cipher_encrypt_unit.sv =====
// Hill cipher encryption of a stream of lowercase letters.
// Input channel: in_valid_i / in_stall_o carry one letter per request with a
// text_end flag on the final letter of the message. A letter is taken at
// every clock edge with valid high and stall low; one letter per cycle is
// sustained without output stall; stall means the two-entry queue is full.
// Output channel: out_valid_o / out_stall_i carry one ciphertext letter per
// request. A block of n letters gives n results, on consecutive cycles if
// the output does not stall; a block cut short by text_end gives as many
// results as it has letters. last_of_run marks the final result of a block,
// message_done the final result of the message. The first result of a block
// passes through the block queue, then the a, b and output registers; the
// column engine gives one result per cycle unless stalled: the output rate.
// Configuration: cfg_valid_i / cfg_ready_o write block size (index 0) and
// key rows 0..3 (indexes 1..4); write only while no letter is in flight.
// Reset clears the partial block, the queue and the pipeline; block size
// returns to 2 and the key to zero. While out_stall_i is high the output
// holds, the pipeline fills behind it, then the queue, then the input stalls.
module hill_cipher_encrypt_unit
  import hce_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_req_t              in_req_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_req_t             out_req_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [KEY_ROW_W-1:0] cfg_data_i
);

  logic [FILL_W-1:0] block_size_q;
  key_mat_t          key_q;
  logic              push;
  logic              q_full;
  logic              q_valid;
  logic              pop;
  job_t              push_job;
  job_t              head_job;

  assign cfg_ready_o = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_size_q <= BLOCK_SIZE_RESET;
      key_q        <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_BLOCK_SIZE: block_size_q <= cfg_data_i[FILL_W-1:0];
        REG_KEY_ROW_0:  key_q[0]     <= cfg_data_i;
        REG_KEY_ROW_1:  key_q[1]     <= cfg_data_i;
        REG_KEY_ROW_2:  key_q[2]     <= cfg_data_i;
        REG_KEY_ROW_3:  key_q[3]     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  hce_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_req_i     (in_req_i),
    .block_size_i (block_size_q),
    .q_full_i     (q_full),
    .push_o       (push),
    .job_o        (push_job)
  );

  hce_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .job_o   (head_job)
  );

  hce_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (q_valid),
    .job_i       (head_job),
    .pop_o       (pop),
    .key_i       (key_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_req_o   (out_req_o)
  );

endmodule

// ===== rtl/hce_checker.sv =====
module hce_checker
  import hce_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input out_req_t out_req_o
);

  // A stalled result stays put.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_req_o))
    else $error("stalled result changed");

  // Every result is a lowercase letter.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_req_o.cipher_letter >= LETTER_BASE) &&
                    (out_req_o.cipher_letter <= LETTER_BASE + LETTER_W'(MODULUS - 1)))
    else $error("result is not a lowercase letter");

  // The end of a message is always the end of a block.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_req_o.message_done |-> out_req_o.last_of_run)
    else $error("message end outside a block end");

  // Columns of one block follow each other without gaps.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_req_o.last_of_run |=> out_valid_o)
    else $error("gap inside a block of results");

endmodule

bind hill_cipher_encrypt_unit hce_checker u_hce_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_req_o   (out_req_o)
);

// ===== tb/sv/tb_hill_cipher_encrypt_unit.sv =====
module tb_hill_cipher_encrypt_unit import hce_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int TOTAL_ITEMS  = 410;
  localparam int QUIET_FROM   = 360;
  localparam int MIDWAY_DRAIN = 200;
  localparam int SETTLE_WAIT  = 8;
  localparam int END_WAIT     = 20;

  // Tracks the cipher state on its own and holds the ciphertext still owed by the block.
  class cipher_ledger;
    logic [FILL_W-1:0]    order_reg;
    logic [KEY_ROW_W-1:0] key_row [MAX_BLOCK];
    logic [VAL_W-1:0]     held [MAX_BLOCK];
    int                   fill;
    out_req_t             due [$];
    int                   errors;

    function new();
      order_reg = BLOCK_SIZE_RESET;
      foreach (key_row[r]) key_row[r] = '0;
      fill = 0;
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [KEY_ROW_W-1:0] data);
      case (idx)
        REG_BLOCK_SIZE: order_reg = data[FILL_W-1:0];
        REG_KEY_ROW_0:  key_row[0] = data;
        REG_KEY_ROW_1:  key_row[1] = data;
        REG_KEY_ROW_2:  key_row[2] = data;
        REG_KEY_ROW_3:  key_row[3] = data;
        default: ;
      endcase
    endfunction

    // Adds one plaintext letter to the block and queues the ciphertext it releases.
    function void take_letter(in_req_t req);
      int               order;
      int               count;
      int               sum;
      logic [VAL_W-1:0] v;
      out_req_t         res;
      // A block size of zero acts as one, and sizes above the maximum are clamped.
      order = (order_reg == 0) ? 1 :
              ((order_reg > MAX_BLOCK) ? MAX_BLOCK : int'(order_reg));
      v = '0;
      if (req.plain_letter >= LETTER_BASE && req.plain_letter < LETTER_BASE + MODULUS) begin
        v = VAL_W'(req.plain_letter - LETTER_BASE);
      end
      if (fill < MAX_BLOCK) begin
        held[fill] = v;
        fill++;
      end
      if (fill < order && !req.text_end) return;
      count = (fill < order) ? fill : order;
      // Row vector times key matrix; positions not yet filled count as zero.
      for (int j = 0; j < count; j++) begin
        sum = 0;
        for (int k = 0; k < order; k++) begin
          if (k < fill) sum += int'(held[k]) * int'(key_row[k][VAL_W*j +: VAL_W]);
        end
        res.cipher_letter = LETTER_BASE + LETTER_W'(sum % MODULUS);
        res.last_of_run   = (j == count - 1);
        res.message_done  = (j == count - 1) && req.text_end;
        due.push_back(res);
      end
      fill = 0;
    endfunction

    // Compares one ciphertext request with the oldest one owed.
    function void check_cipher(out_req_t got);
      out_req_t want;
      if (due.size() == 0) begin
        $display("%0t: ciphertext %0d arrived with nothing outstanding", $time,
                 got.cipher_letter);
        errors++;
        return;
      end
      want = due.pop_front();
      if (got.cipher_letter !== want.cipher_letter) begin
        $display("%0t: cipher_letter expected %0d got %0d", $time, want.cipher_letter,
                 got.cipher_letter);
        errors++;
      end
      if (got.last_of_run !== want.last_of_run) begin
        $display("%0t: last_of_run expected %0b got %0b", $time, want.last_of_run,
                 got.last_of_run);
        errors++;
      end
      if (got.message_done !== want.message_done) begin
        $display("%0t: message_done expected %0b got %0b", $time, want.message_done,
                 got.message_done);
        errors++;
      end
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_req_t              in_req = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_req_t             out_req;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [KEY_ROW_W-1:0] cfg_data = '0;

  cipher_ledger ledger = new();
  int           cycle_count = 0;
  int           sent = 0;
  bit           quiet = 1'b0;

  hill_cipher_encrypt_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_req_o   (out_req),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Observe every handshake at the rising edge.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (rst_ni) begin
      if (cfg_valid && cfg_ready) ledger.write_reg(cfg_index, cfg_data);
      if (in_valid && !in_stall) ledger.take_letter(in_req);
      if (out_valid && !out_stall) ledger.check_cipher(out_req);
    end
  end

  // The receiver stalls in random bursts until the closing part of the run.
  initial begin
    forever begin
      @(negedge clk_i);
      if (!quiet && $urandom_range(0, 5) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 9)) @(negedge clk_i);
        out_stall = 1'b0;
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk_i);
    $display("hill_cipher_encrypt_unit verification failed");
    $finish;
  end

  // Presents one letter and holds it until the block takes it.
  // Stall only changes at rising edges, so its value between edges decides the next edge.
  task automatic send_letter(input byte code, input bit fin);
    bit stalled;
    in_req.plain_letter = code[LETTER_W-1:0];
    in_req.text_end     = fin;
    in_valid            = 1'b1;
    stalled             = in_stall;
    @(posedge clk_i);
    while (stalled) begin
      @(negedge clk_i);
      stalled = in_stall;
      @(posedge clk_i);
    end
    @(negedge clk_i);
    sent++;
  endtask

  task automatic rest(input int cycles);
    in_valid = 1'b0;
    repeat (cycles) @(negedge clk_i);
  endtask

  // Stops sending until all owed ciphertext is out and any partial block has settled.
  task automatic settle();
    in_valid = 1'b0;
    while (ledger.due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_WAIT) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic load_reg(input logic [CFG_IDX_W-1:0] idx, input logic [KEY_ROW_W-1:0] data);
    cfg_index = idx;
    cfg_data  = data;
    cfg_valid = 1'b1;
    do @(posedge clk_i); while (!cfg_ready);
    @(negedge clk_i);
  endtask

  // Picks a new block size and, when asked, a new key: all zero, all ones or random.
  task automatic new_settings(input bit whole);
    logic [FILL_W-1:0] size;
    int                mode;
    settle();
    size = ($urandom_range(0, 9) < 7) ? FILL_W'($urandom_range(1, MAX_BLOCK)) :
                                        FILL_W'($urandom_range(0, 7));
    load_reg(REG_BLOCK_SIZE, {(KEY_ROW_W-FILL_W)'($urandom), size});
    if (whole) begin
      mode = $urandom_range(0, 5);
      for (int r = 0; r < MAX_BLOCK; r++) begin
        load_reg(CFG_IDX_W'(REG_KEY_ROW_0 + r),
                 (mode == 0) ? '0 : ((mode == 1) ? '1 : KEY_ROW_W'($urandom)));
      end
    end
    cfg_valid = 1'b0;
  endtask

  // Mostly letters, now and then a code outside a..z on either side of the range.
  function automatic byte pick_code();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return byte'($urandom_range(0, LETTER_BASE - 1));
    if (r == 1) return byte'($urandom_range(LETTER_BASE + MODULUS, 127));
    return byte'($urandom_range(LETTER_BASE, LETTER_BASE + MODULUS - 1));
  endfunction

  initial begin
    int len;
    bit drained;
    drained = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Reset settings: block of two under an all-zero key.
    send_letter("h", 1'b0);
    send_letter("i", 1'b0);
    settle();

    // Blocks of four, a row of all-ones entries and entries just above 25.
    load_reg(REG_BLOCK_SIZE, KEY_ROW_W'(4));
    load_reg(REG_KEY_ROW_0, '1);
    load_reg(REG_KEY_ROW_1, KEY_ROW_W'($urandom));
    load_reg(REG_KEY_ROW_2, {5'd25, 5'd26, 5'd1, 5'd0});
    load_reg(REG_KEY_ROW_3, KEY_ROW_W'($urandom));
    for (int i = int'(REG_KEY_ROW_3) + 1; i < 2**CFG_IDX_W; i++) begin
      load_reg(CFG_IDX_W'(i), KEY_ROW_W'($urandom));
    end
    cfg_valid = 1'b0;

    // Letter extremes and codes just outside the letter range.
    send_letter("a", 1'b0);
    send_letter("z", 1'b0);
    send_letter(byte'(LETTER_BASE - 1), 1'b0);
    send_letter(byte'(LETTER_BASE + MODULUS), 1'b0);
    // Short final block with the smallest and largest codes.
    send_letter(8'd0, 1'b0);
    send_letter(8'd127, 1'b0);
    send_letter("m", 1'b1);

    // Shrink the block size while two letters are held.
    send_letter("b", 1'b0);
    send_letter("c", 1'b0);
    settle();
    load_reg(REG_BLOCK_SIZE, KEY_ROW_W'(1));
    cfg_valid = 1'b0;
    send_letter("d", 1'b0);

    // Size zero acts as one, size seven as the maximum.
    settle();
    load_reg(REG_BLOCK_SIZE, '0);
    cfg_valid = 1'b0;
    send_letter("y", 1'b1);
    settle();
    load_reg(REG_BLOCK_SIZE, '1);
    cfg_valid = 1'b0;
    send_letter("q", 1'b0);
    send_letter("r", 1'b0);
    send_letter("s", 1'b0);
    send_letter("t", 1'b1);

    // A message ending one letter short of a block of three.
    settle();
    load_reg(REG_BLOCK_SIZE, KEY_ROW_W'(3));
    cfg_valid = 1'b0;
    send_letter("x", 1'b0);
    send_letter("w", 1'b1);

    // Random messages under changing settings.
    while (sent < TOTAL_ITEMS) begin
      if (!quiet && $urandom_range(0, 5) == 0) new_settings($urandom_range(0, 2) != 0);
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 30) : $urandom_range(1, 12);
      for (int i = 0; i < len; i++) begin
        if (sent >= QUIET_FROM) quiet = 1'b1;
        if (!quiet && $urandom_range(0, 3) == 0) rest($urandom_range(1, 9));
        if (!quiet && $urandom_range(0, 49) == 0) new_settings(1'b0);
        if (!drained && sent >= MIDWAY_DRAIN) begin
          settle();
          drained = 1'b1;
        end
        send_letter(pick_code(), i == len - 1);
      end
    end

    in_valid = 1'b0;
    while (ledger.due.size() != 0) @(posedge clk_i);
    repeat (END_WAIT) @(posedge clk_i);
    if (ledger.errors == 0) begin
      $display("hill_cipher_encrypt_unit verification clean");
    end else begin
      $display("hill_cipher_encrypt_unit verification failed");
    end
    $finish;
  end

endmodule

// ===== hill_cipher_encrypt_unit.f =====
rtl/hce_pkg.sv
rtl/hce_front.sv
rtl/hce_queue.sv
rtl/hce_back.sv
rtl/hill_cipher_encrypt_unit.sv
rtl/hce_checker.sv
tb/sv/tb_hill_cipher_encrypt_unit.sv
